// ===== rtl/cbsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsr_pkg
// Shared types and constants of the cubic B-spline line resampler.
// ----------------------------------------------------------------------------
package cbsr_pkg;

	localparam int LineMax     = 4096;
	localparam int PosFracBits = 16;
	localparam int SampleBits  = 15;
	localparam int SampleFrac  = 4;
	localparam int TBits       = 12;
	localparam int MaxResults  = 51;
	localparam int LenW        = 13;
	localparam int StepW       = 21;
	localparam int PosW        = 29;
	localparam int CntW        = 6;
	localparam int QDepth      = 2;

	localparam logic [1:0] REG_SRC_LEN  = 2'd0;
	localparam logic [1:0] REG_OUT_LEN  = 2'd1;
	localparam logic [1:0] REG_STEP     = 2'd2;

	// One output job handed from the front to the back.
	typedef struct packed {
		logic [TBits-1:0]      t;
		logic signed [SampleBits-1:0] s0;
		logic signed [SampleBits-1:0] s1;
		logic signed [SampleBits-1:0] s2;
		logic signed [SampleBits-1:0] s3;
		logic                  run_last;
		logic                  line_done;
	} job_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_EMIT
	} front_state_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       run_last;
		logic       line_done;
	} res_t;

endpackage

// ===== rtl/cbsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsr_front
// Accepts samples, keeps the window and position, and issues one job per
// output with the four mirrored neighbours and the fraction.
// ----------------------------------------------------------------------------
module cbsr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [cbsr_pkg::SampleBits-1:0] sample,
	input  logic [cbsr_pkg::LenW-1:0]        src_len,
	input  logic [cbsr_pkg::LenW-1:0]        out_len,
	input  logic [cbsr_pkg::StepW-1:0]       step_eff,
	output logic                             job_valid,
	input  logic                             job_ready,
	output cbsr_pkg::job_t                   job
);
	import cbsr_pkg::*;

	localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

	front_state_t state_q, state_d;
	logic signed [SampleBits-1:0] win_q [4];
	logic [LenW-1:0] seen_q, done_q, s_q;
	logic [PosW-1:0] pos_q;
	logic [CntW-1:0] cnt_q;
	logic            last_q;

	logic [PosW-LenW-PosFracBits+LenW-1:0] n_full;
	logic [LenW-1:0] n, last_idx;
	logic            clamp, due, fin, more;
	logic [TBits-1:0] t;
	logic [PosW:0]   pos_sum;

	assign n_full   = pos_q[PosW-1:PosFracBits];
	assign last_idx = src_len - 1'b1;
	assign clamp    = n_full > {1'b0, last_idx};
	assign n        = clamp ? last_idx : n_full[LenW-1:0];
	assign t        = clamp ? '0 : pos_q[PosFracBits-1 -: TBits];
	assign due      = (done_q < out_len) && (cnt_q < CntW'(MaxResults))
		&& (last_q || ({1'b0, n} + 14'd2 <= {1'b0, s_q}));
	assign pos_sum  = {1'b0, pos_q} + (PosW+1)'(step_eff);

	// Mirrored neighbour index, then its place in the window.
	function automatic logic signed [SampleBits-1:0] pick(
		input logic [LenW-1:0] base, input logic [1:0] k,
		input logic [LenW-1:0] lst, input logic [LenW-1:0] s,
		input logic signed [SampleBits-1:0] w0, input logic signed [SampleBits-1:0] w1,
		input logic signed [SampleBits-1:0] w2, input logic signed [SampleBits-1:0] w3);
		logic signed [LenW+2:0] i;
		logic signed [LenW+2:0] d;
		i = $signed({3'b0, base}) - (LenW+3)'(1) + $signed({14'b0, k});
		if (i < 0) i = -i;
		if (i > $signed({3'b0, lst})) i = $signed({2'b0, lst, 1'b0}) - i;
		if (i < 0) i = 0;
		d = $signed({3'b0, s}) - i;
		if (d <= 0) return w0;
		else if (d == 1) return w1;
		else if (d == 2) return w2;
		else return w3;
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (in_valid) state_d = FR_EMIT;
			FR_EMIT: if (!due || job_ready) begin
				if (!due || !more) state_d = FR_IDLE;
			end
			default: state_d = FR_IDLE;
		endcase
	end

	// Whether another output follows the one on offer.
	always_comb begin
		logic [LenW-1:0] nd;
		logic [PosW-1:0] np;
		logic [PosW-PosFracBits-1:0] nn;
		nd = done_q + 1'b1;
		np = pos_sum > {1'b0, PosMax} ? PosMax : pos_sum[PosW-1:0];
		nn = np[PosW-1:PosFracBits];
		more = (nd < out_len) && (cnt_q + 1'b1 < CntW'(MaxResults))
			&& (last_q || ({1'b0, nn} + 14'd2 <= {1'b0, s_q}));
		fin = (nd == out_len) || (last_q && !more);
	end

	assign in_ready  = (state_q == FR_IDLE);
	assign job_valid = (state_q == FR_EMIT) && due;
	assign job.t     = t;
	assign job.s0    = pick(n, 2'd0, last_idx, s_q, win_q[0], win_q[1], win_q[2], win_q[3]);
	assign job.s1    = pick(n, 2'd1, last_idx, s_q, win_q[0], win_q[1], win_q[2], win_q[3]);
	assign job.s2    = pick(n, 2'd2, last_idx, s_q, win_q[0], win_q[1], win_q[2], win_q[3]);
	assign job.s3    = pick(n, 2'd3, last_idx, s_q, win_q[0], win_q[1], win_q[2], win_q[3]);
	assign job.run_last  = !more;
	assign job.line_done = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			seen_q  <= '0;
			done_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			s_q     <= '0;
			for (int k = 0; k < 4; k++) win_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FR_IDLE && in_valid) begin
				win_q[0] <= sample;
				win_q[1] <= win_q[0];
				win_q[2] <= win_q[1];
				win_q[3] <= win_q[2];
				s_q      <= seen_q;
				last_q   <= seen_q >= last_idx;
				cnt_q    <= '0;
			end else if (job_valid && job_ready) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// The end of the line clears the counters, even on the cycle of its last job.
			if (state_q == FR_EMIT && state_d == FR_IDLE && last_q) begin
				seen_q <= '0;
				done_q <= '0;
				pos_q  <= '0;
			end else begin
				if (job_valid && job_ready) begin
					done_q <= done_q + 1'b1;
					pos_q  <= pos_sum > {1'b0, PosMax} ? PosMax : pos_sum[PosW-1:0];
				end
				if (state_q == FR_EMIT && state_d == FR_IDLE) seen_q <= s_q + 1'b1;
			end
		end
	end

	a_no_job_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FR_IDLE |-> !job_valid) else $error("job while idle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(MaxResults)) else $error("run too long");
	a_job_hold: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_ready |=> job_valid) else $error("job dropped while stalled");

endmodule

// ===== rtl/cbsr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsr_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module cbsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  cbsr_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output cbsr_pkg::job_t rd_data
);
	import cbsr_pkg::*;

	job_t       mem_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer skew");
	a_ptr1: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> wp_q != rp_q) else $error("pointer skew");

endmodule

// ===== rtl/cbsr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbsr_back
// Computes the weights and the weighted sum of one job over a short pipeline
// and holds the result in a two-entry output buffer.
// ----------------------------------------------------------------------------
module cbsr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  cbsr_pkg::job_t job,
	output logic           empty,
	input  logic           pop,
	output cbsr_pkg::res_t res
);
	import cbsr_pkg::*;

	localparam int WW = 3*TBits + 4;       // weights times 6, up to 4*2^36
	localparam int AW = WW + SampleBits + 3;
	localparam int DenSh = 3*TBits + SampleFrac;
	localparam logic signed [AW-1:0] Half = AW'(64'sd3 <<< DenSh);

	// Stage 1: squares.  Stage 2: cubes and weights.  Stage 3: products.
	// Stage 4: sum.  The divide by the constant denominator follows as a
	// shift and a small reciprocal multiply.
	logic v_s1, v_s2, v_s3, v_s4;
	job_t j_s1, j_s2, j_s3;
	logic [TBits:0] tt_s1, uu_s1;
	logic [2*TBits+1:0] t2_s1, u2_s1;
	logic [WW-1:0] w_s2 [4];
	logic signed [AW-1:0] p_s3 [4];
	logic signed [AW-1:0] acc_s4;
	logic                 rl_s4, ld_s4;

	// Output buffer.
	res_t buf_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [1:0] inflight;
	logic push, rd;
	logic [7:0] px;
	logic signed [AW-1:0] sh;
	logic [10:0] xq;
	logic [22:0] prod;

	assign inflight  = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);
	// Stall-free pipe: only accept when the buffer can take every job in it.
	assign job_ready = (32'(cnt_q) + 32'(inflight) + 32'(v_s4)) < 2;
	assign empty     = cnt_q == 2'd0;
	assign res       = buf_q[rp_q];
	assign rd        = !empty && pop;
	assign push      = v_s4;

	// The denominator is 6 * 2^40, so the quotient is floor((sum >> 40) / 6);
	// the division by 6 is a multiply by 2731 / 2^14, exact below 2048.
	always_comb begin
		sh   = acc_s4 + Half;
		xq   = sh[DenSh +: 11];
		prod = 23'(xq) * 23'(12'd2731);
		if (sh < 0) px = 8'd0;
		else if ((|sh[AW-2:DenSh+11]) || prod[22:14] > 9'd255) px = 8'd255;
		else px = prod[21:14];
	end

	always_ff @(posedge clk) begin
		logic [TBits:0] tt, uu;
		tt = {1'b0, job.t};
		uu = (TBits+1)'(1 << TBits) - tt;
		tt_s1 <= tt;
		uu_s1 <= uu;
		t2_s1 <= (2*TBits+2)'(tt) * (2*TBits+2)'(tt);
		u2_s1 <= (2*TBits+2)'(uu) * (2*TBits+2)'(uu);
		j_s1  <= job;
		w_s2[0] <= WW'(u2_s1) * WW'(uu_s1);
		w_s2[3] <= WW'(t2_s1) * WW'(tt_s1);
		w_s2[1] <= (WW'(4) << (3*TBits)) - WW'(6) * (WW'(t2_s1) << TBits)
			+ WW'(3) * WW'(t2_s1) * WW'(tt_s1);
		w_s2[2] <= (WW'(4) << (3*TBits)) - WW'(6) * (WW'(u2_s1) << TBits)
			+ WW'(3) * WW'(u2_s1) * WW'(uu_s1);
		j_s2 <= j_s1;
		p_s3[0] <= AW'($signed({1'b0, w_s2[0]})) * AW'(j_s2.s0);
		p_s3[1] <= AW'($signed({1'b0, w_s2[1]})) * AW'(j_s2.s1);
		p_s3[2] <= AW'($signed({1'b0, w_s2[2]})) * AW'(j_s2.s2);
		p_s3[3] <= AW'($signed({1'b0, w_s2[3]})) * AW'(j_s2.s3);
		j_s3 <= j_s2;
		acc_s4 <= p_s3[0] + p_s3[1] + p_s3[2] + p_s3[3];
		rl_s4  <= j_s3.run_last;
		ld_s4  <= j_s3.line_done;
		if (push) buf_q[wp_q] <= '{pixel: px, run_last: rl_s4, line_done: ld_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			v_s1 <= job_valid && job_ready;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			if (push) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, rd};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2 || rd)) else $error("result buffer overflow");
	a_cnt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("buffer count out of range");
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2) else $error("pipeline lost a job");

endmodule

// ===== rtl/cubic_bspline_line_resampler_core.sv =====
`timescale 1ns / 1ps
// Path: the first output word of an accepted sample passes the front end's window
// registers, the job queue, the back end's pipeline stages and its output buffer.
// Flow: the front end takes no new sample until it has issued all output words of the
// last one, and the back end takes a job only when its buffer can hold all it has in flight.
// Reset: asynchronous, clears window, counters and queues; registers go to 512, 512, 65536.
// ----------------------------------------------------------------------------
// cubic_bspline_line_resampler_core
// Top level: configuration registers, front end, job queue and back end.
// ----------------------------------------------------------------------------
module cubic_bspline_line_resampler_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [cbsr_pkg::SampleBits-1:0] sample,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [7:0]                           pixel,
	output logic                                 run_last,
	output logic                                 line_done,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [cbsr_pkg::StepW-1:0]           cfg_data
);
	import cbsr_pkg::*;

	logic [LenW-1:0]  src_q, out_q, src_e, out_e;
	logic [StepW-1:0] step_q, step_e;
	logic in_ready, fj_valid, fj_ready, bj_valid, bj_ready;
	job_t fjob, bjob;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q  <= LenW'(512);
			out_q  <= LenW'(512);
			step_q <= StepW'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_LEN: src_q  <= cfg_data[LenW-1:0];
				REG_OUT_LEN: out_q  <= cfg_data[LenW-1:0];
				REG_STEP:    step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign src_e  = src_q < LenW'(4) ? LenW'(4) : (src_q > LenW'(LineMax) ? LenW'(LineMax) : src_q);
	assign out_e  = out_q < LenW'(1) ? LenW'(1) : (out_q > LenW'(LineMax) ? LenW'(LineMax) : out_q);
	assign step_e = step_q < StepW'(1 << (PosFracBits-4)) ? StepW'(1 << (PosFracBits-4)) : step_q;
	assign full   = !in_ready;

	cbsr_front u_front (
		.clk, .arst_n, .in_valid(push), .in_ready, .sample,
		.src_len(src_e), .out_len(out_e), .step_eff(step_e),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
	);

	cbsr_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fjob),
		.rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bjob)
	);

	cbsr_back u_back (
		.clk, .arst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
		.empty, .pop, .res
	);

	assign pixel     = res.pixel;
	assign run_last  = res.run_last;
	assign line_done = res.line_done;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic B-spline line resampler testbench
// Feeds source lines through the queue-style ports. A cycle-free predictor
// computes the expected output words and compares them field by field.
// Several register settings are used, among them the extremes and values out
// of range. Both sides idle at random, and the receiver stalls at length once.
// ----------------------------------------------------------------------------
module testbench;
	import cbsr_pkg::*;

	typedef struct {
		logic [7:0] pixel;
		logic       run_last;
		logic       line_done;
	} pix_word_t;

	int mismatches;

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Expected output words, plus a predictor of the block.
	class pixel_scoreboard;
		pix_word_t          pending[$];
		int                 matched;
		logic [LenW-1:0]    src_len_reg;
		logic [LenW-1:0]    out_len_reg;
		logic [StepW-1:0]   step_reg;
		longint             taps[4];
		int unsigned        seen;
		int unsigned        done_cnt;
		longint unsigned    pos;

		function new();
			matched = 0;
			src_len_reg = 512;
			out_len_reg = 512;
			step_reg = 65536;
			clear_line();
			foreach (taps[k]) taps[k] = 0;
		endfunction

		function void clear_line();
			seen = 0;
			done_cnt = 0;
			pos = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [StepW-1:0] val);
			case (idx)
				REG_SRC_LEN: src_len_reg = val[LenW-1:0];
				REG_OUT_LEN: out_len_reg = val[LenW-1:0];
				REG_STEP: step_reg = val;
				default: ;
			endcase
		endfunction

		function longint tap_at(longint i, longint len, longint s);
			longint lst, d;
			lst = len - 1;
			if (i < 0) i = -i;
			if (i > lst) i = 2 * lst - i;
			if (i < 0) i = 0;
			if (i > lst) i = lst;
			d = s - i;
			if (d < 0) d = 0;
			if (d > 3) d = 3;
			return taps[d];
		endfunction

		function logic [7:0] blend(longint unsigned p, longint len, longint s);
			longint n, tt, uu, acc, den;
			longint w[4];
			n = longint'(p >> PosFracBits);
			tt = 0;
			if (n > len - 1) n = len - 1;
			else tt = longint'((p & ((1 << PosFracBits) - 1)) >> (PosFracBits - TBits));
			uu = (longint'(1) << TBits) - tt;
			w[0] = uu * uu * uu;
			w[1] = (longint'(4) << (3 * TBits)) - 6 * tt * tt * (longint'(1) << TBits)
				+ 3 * tt * tt * tt;
			w[2] = (longint'(4) << (3 * TBits)) - 6 * uu * uu * (longint'(1) << TBits)
				+ 3 * uu * uu * uu;
			w[3] = tt * tt * tt;
			acc = 0;
			for (int k = 0; k < 4; k++) acc += w[k] * tap_at(n - 1 + k, len, s);
			den = longint'(6) << (3 * TBits + SampleFrac);
			acc += den / 2;
			if (acc < 0) return 8'd0;
			acc = acc / den;
			return (acc > 255) ? 8'd255 : acc[7:0];
		endfunction

		function void note_sample(logic signed [SampleBits-1:0] smp);
			longint len, outlen, n;
			longint unsigned stp, pmax;
			int cnt;
			bit lastsmp;
			pix_word_t w;
			len = src_len_reg;
			if (len < 4) len = 4;
			if (len > LineMax) len = LineMax;
			outlen = out_len_reg;
			if (outlen < 1) outlen = 1;
			if (outlen > LineMax) outlen = LineMax;
			stp = step_reg;
			if (stp < (1 << (PosFracBits - 4))) stp = 1 << (PosFracBits - 4);
			pmax = (longint'(LineMax) << (PosFracBits + 1)) - 1;
			lastsmp = seen >= len - 1;
			for (int k = 3; k > 0; k--) taps[k] = taps[k-1];
			taps[0] = smp;
			cnt = 0;
			while (cnt < MaxResults && done_cnt < outlen) begin
				n = longint'(pos >> PosFracBits);
				if (!lastsmp && n + 2 > seen) break;
				w.pixel = blend(pos, len, seen);
				w.run_last = 0;
				done_cnt++;
				w.line_done = (done_cnt == outlen);
				pos += stp;
				if (pos > pmax) pos = pmax;
				pending.push_back(w);
				cnt++;
			end
			if (cnt > 0) begin
				pending[$].run_last = 1;
				if (lastsmp) pending[$].line_done = 1;
			end
			if (lastsmp) clear_line();
			else seen++;
		endfunction

		task check_word(pix_word_t got);
			pix_word_t exp_w;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected word pixel=%0d", got.pixel));
				return;
			end
			exp_w = pending.pop_front();
			if (got.pixel !== exp_w.pixel)
				report_mismatch($sformatf("pixel %0d, expected %0d", got.pixel,
					exp_w.pixel));
			if (got.run_last !== exp_w.run_last)
				report_mismatch($sformatf("run_last %b, expected %b", got.run_last,
					exp_w.run_last));
			if (got.line_done !== exp_w.line_done)
				report_mismatch($sformatf("line_done %b, expected %b", got.line_done,
					exp_w.line_done));
			matched++;
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         push;
	logic                         full;
	logic signed [SampleBits-1:0] sample;
	logic                         empty;
	logic                         pop;
	logic [7:0]                   pixel;
	logic                         run_last;
	logic                         line_done;
	logic                         cfg_we;
	logic [1:0]                   cfg_index;
	logic [StepW-1:0]             cfg_data;

	pixel_scoreboard sb;
	longint          cycles = 0;
	int              lines_sent;
	int              samples_sent;
	bit              hold_off;

	cubic_bspline_line_resampler_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .pixel(pixel), .run_last(run_last),
		.line_done(line_done), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Output side: random pops, sampled at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && pop && !empty)
			sb.check_word('{pixel: pixel, run_last: run_last, line_done: line_done});
	end

	initial begin
		int g;
		pop = 0;
		forever begin
			@(negedge clk);
			if (hold_off) pop <= 0;
			else if (g > 0) begin
				pop <= 0;
				g--;
			end else begin
				pop <= 1;
				g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			end
		end
	end

	task automatic send_sample(logic signed [SampleBits-1:0] v);
		int g;
		g = gap_len();
		repeat (g + 1) @(negedge clk);
		push <= 1;
		sample <= v;
		@(posedge clk iff !full);
		sb.note_sample(v);
		samples_sent++;
		@(negedge clk);
		push <= 0;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [StepW-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_line(int src, int outn, int stp);
		wait_idle();
		write_reg(REG_SRC_LEN, StepW'(src));
		write_reg(REG_OUT_LEN, StepW'(outn));
		write_reg(REG_STEP, StepW'(stp));
	endtask

	function automatic logic signed [SampleBits-1:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return SampleBits'($urandom());
		if (r == 1) return ($urandom_range(0, 1) != 0) ? 15'sh3FFF : 15'sh4000;
		return SampleBits'($urandom_range(0, 4095 + 400) - 200);
	endfunction

	task automatic send_line(int n);
		for (int i = 0; i < n; i++) send_sample(rand_sample());
		lines_sent++;
	endtask

	initial begin
		push = 0;
		sample = 0;
		cfg_we = 0;
		cfg_index = REG_SRC_LEN;
		cfg_data = 0;
		arst_n = 0;
		mismatches = 0;
		hold_off = 0;
		lines_sent = 0;
		samples_sent = 0;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes at reset settings, short partial line.
		send_sample(15'sh3FFF);
		send_sample(15'sh4000);
		send_sample(15'sh0000);
		send_sample(15'sh7FFF);
		send_sample(15'sh0FF0);
		// Minimum source, upscaling past the cap of words per sample.
		set_line(0, 4096, 4096);
		send_line(4);
		// Short output of two words at a large step, the second one from the last sample.
		set_line(4, 2, 1048576);
		send_line(4);
		// Step below the floor, source clamp, output of one.
		set_line(8191, 0, 0);
		send_line(3);
		set_line(5, 8191, 3 * 65536);
		send_line(5);

		// Receiver holds off while the sender keeps pushing.
		set_line(6, 60, 5461);
		fork
			begin
				hold_off = 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			send_line(6);
		join

		while (samples_sent < 340) begin
			int src, outn, stp, r;
			r = $urandom_range(0, 9);
			src = (r == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
			outn = (r == 1) ? $urandom_range(0, 8191) : $urandom_range(1, 40);
			stp = (r == 2) ? $urandom_range(0, 4095) :
				$urandom_range(4096, (r == 3) ? 2097151 : 262144);
			if (r > 4 && outn > 1 && src > 1)
				stp = ((src - 1) << PosFracBits) / (outn - 1);
			set_line(src, outn, stp);
			send_line(($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) :
				(src < 4 ? 4 : src));
		end

		wait_idle();
		$display("Sent %0d samples in %0d lines; %0d output words checked.",
			samples_sent, lines_sent, sb.matched);
		if (mismatches == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		wait (cycles > 3000000);
		$display("Timeout after %0d cycles", cycles);
		$display("Test completed with failures");
		$finish;
	end
endmodule
